// ===== hw/rtl/httok_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP request tokenizer package
// Payload types, token class codes and slot limits shared by the tokenizer.
// ----------------------------------------------------------------------------
package httok_pkg;

   localparam int unsigned MAX_ARGS    = 16;
   localparam int unsigned MAX_HEADERS = 32;

   localparam logic [2:0] PH_METHOD = 3'd0;
   localparam logic [2:0] PH_PATH   = 3'd1;
   localparam logic [2:0] PH_AKEY   = 3'd2;
   localparam logic [2:0] PH_AVAL   = 3'd3;
   localparam logic [2:0] PH_PROTO  = 3'd4;
   localparam logic [2:0] PH_HKEY   = 3'd5;
   localparam logic [2:0] PH_HVAL   = 3'd6;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       kept;
      logic [2:0] token_class;
      logic [7:0] token_index;
      logic       token_first;
      logic       over_limit;
      logic [7:0] arg_total;
      logic [7:0] header_total;
      logic       out_last;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/http_request_tokenizer_core.sv =====
// Path: each accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled by rsp_ready held
// low; the parse step between the input register and the result register is combinational.
// Reset: synchronous, active high; clears both stage valid flags and returns
// the parser to the method phase with zeroed counters.
// ----------------------------------------------------------------------------
// HTTP request tokenizer core
// Tags each byte of a request head with its token class, slot and flags, and lowercases header-name letters.
// ----------------------------------------------------------------------------
module http_request_tokenizer_core #(
   parameter int unsigned MAX_ARGS    = httok_pkg::MAX_ARGS,
   parameter int unsigned MAX_HEADERS = httok_pkg::MAX_HEADERS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  httok_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output httok_pkg::rsp_payload_type rsp_payload
);

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUERY  = 8'h3F;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;

   localparam logic [7:0] ARG_LIMIT    = 8'(MAX_ARGS);
   localparam logic [7:0] HEADER_LIMIT = 8'(MAX_HEADERS);
   localparam logic [7:0] COUNT_MAX    = 8'hFF;

   logic                       in_valid_ff;
   httok_pkg::req_payload_type in_item_ff;
   logic                       out_valid_ff;
   httok_pkg::rsp_payload_type out_item_ff;
   httok_pkg::rsp_payload_type out_item_in;

   logic [2:0] phase_ff, phase_in;
   logic       skip_ff, skip_in;
   logic       swallow_ff, swallow_in;
   logic       pending_ff, pending_in;
   logic [7:0] arg_cnt_ff, arg_cnt_in;
   logic [7:0] hdr_cnt_ff, hdr_cnt_in;

   logic       advance;
   logic [7:0] b;
   logic [2:0] cls;
   logic [7:0] idx;
   logic       over;
   logic [7:0] ob;
   logic       kept;
   logic       first;
   logic       line_end;
   logic       handled;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_item_ff;

   always_comb begin
      b          = in_item_ff.in_byte;
      cls        = (phase_ff > httok_pkg::PH_HVAL) ? httok_pkg::PH_HVAL : phase_ff;
      idx        = 8'd0;
      over       = 1'b0;
      ob         = b;
      kept       = 1'b0;
      first      = 1'b0;
      line_end   = (b == CH_CR) || (b == CH_LF);
      handled    = 1'b0;
      phase_in   = phase_ff;
      skip_in    = skip_ff;
      swallow_in = 1'b0;
      pending_in = pending_ff;
      arg_cnt_in = arg_cnt_ff;
      hdr_cnt_in = hdr_cnt_ff;

      case (cls)
         httok_pkg::PH_AKEY: begin
            idx  = arg_cnt_ff;
            over = idx >= ARG_LIMIT;
         end
         httok_pkg::PH_AVAL: begin
            idx  = (arg_cnt_ff == 8'd0) ? 8'd0 : arg_cnt_ff - 8'd1;
            over = idx >= ARG_LIMIT;
         end
         httok_pkg::PH_HKEY: begin
            idx  = hdr_cnt_ff;
            over = idx >= HEADER_LIMIT;
         end
         httok_pkg::PH_HVAL: begin
            idx  = (hdr_cnt_ff == 8'd0) ? 8'd0 : hdr_cnt_ff - 8'd1;
            over = idx >= HEADER_LIMIT;
         end
         default: begin
            idx  = 8'd0;
            over = 1'b0;
         end
      endcase

      if (swallow_ff && line_end) begin
         handled = 1'b1;
      end
      if (!handled && skip_ff) begin
         if (b == CH_SPACE) begin
            handled = 1'b1;
         end else begin
            skip_in = 1'b0;
         end
      end

      if (!handled) begin
         if (line_end) begin
            phase_in   = httok_pkg::PH_HKEY;
            pending_in = 1'b1;
            swallow_in = 1'b1;
         end else begin
            unique case (cls)
               httok_pkg::PH_METHOD: begin
                  if (b == CH_SPACE) begin
                     phase_in   = httok_pkg::PH_PATH;
                     pending_in = 1'b1;
                     skip_in    = 1'b1;
                  end else begin
                     kept = 1'b1;
                  end
               end
               httok_pkg::PH_PATH: begin
                  if (b == CH_SPACE) begin
                     phase_in   = httok_pkg::PH_PROTO;
                     pending_in = 1'b1;
                     skip_in    = 1'b1;
                  end else if (b == CH_QUERY) begin
                     phase_in   = httok_pkg::PH_AKEY;
                     pending_in = 1'b1;
                  end else begin
                     kept = 1'b1;
                  end
               end
               httok_pkg::PH_AKEY, httok_pkg::PH_AVAL: begin
                  if (b == CH_SPACE) begin
                     phase_in   = httok_pkg::PH_PROTO;
                     pending_in = 1'b1;
                     skip_in    = 1'b1;
                  end else if (b == CH_EQUALS) begin
                     arg_cnt_in = (arg_cnt_ff == COUNT_MAX) ? COUNT_MAX : arg_cnt_ff + 8'd1;
                     phase_in   = httok_pkg::PH_AVAL;
                     pending_in = 1'b1;
                  end else if (b == CH_AMP) begin
                     phase_in   = httok_pkg::PH_AKEY;
                     pending_in = 1'b1;
                  end else begin
                     kept = 1'b1;
                  end
               end
               httok_pkg::PH_HKEY: begin
                  if (b == CH_COLON) begin
                     hdr_cnt_in = (hdr_cnt_ff == COUNT_MAX) ? COUNT_MAX : hdr_cnt_ff + 8'd1;
                     phase_in   = httok_pkg::PH_HVAL;
                     pending_in = 1'b1;
                     skip_in    = 1'b1;
                  end else begin
                     kept = 1'b1;
                     if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
                        ob = b + 8'd32;
                     end
                  end
               end
               default: begin
                  kept = 1'b1;
               end
            endcase
         end
      end

      if (kept) begin
         first      = pending_ff;
         pending_in = 1'b0;
      end

      out_item_in.out_byte     = ob;
      out_item_in.kept         = kept;
      out_item_in.token_class  = cls;
      out_item_in.token_index  = idx;
      out_item_in.token_first  = first;
      out_item_in.over_limit   = over;
      out_item_in.arg_total    = arg_cnt_in;
      out_item_in.header_total = hdr_cnt_in;
      out_item_in.out_last     = in_item_ff.in_last;

      if (in_item_ff.in_last) begin
         phase_in   = httok_pkg::PH_METHOD;
         skip_in    = 1'b0;
         swallow_in = 1'b0;
         pending_in = 1'b1;
         arg_cnt_in = 8'd0;
         hdr_cnt_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= httok_pkg::PH_METHOD;
         skip_ff      <= 1'b0;
         swallow_ff   <= 1'b0;
         pending_ff   <= 1'b1;
         arg_cnt_ff   <= 8'd0;
         hdr_cnt_ff   <= 8'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            skip_ff      <= skip_in;
            swallow_ff   <= swallow_in;
            pending_ff   <= pending_in;
            arg_cnt_ff   <= arg_cnt_in;
            hdr_cnt_ff   <= hdr_cnt_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

endmodule
